### src/assert_macros.svh
// Assertion macros for the RTL of the lagged covariance engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### src/lce_pkg.sv
// Shared types and codes of the lagged covariance engine.
package lce_pkg;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic CSR_NUM_FEATURES = 1'b0;
   localparam logic CSR_LAG_FRAMES   = 1'b1;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_LAG  = 2'd1,
      ST_NONE = 2'd2,
      ST_OVF  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_FINISH,
      CS_SETUP,
      CS_PAIR,
      CS_RD_I,
      CS_RD_J,
      CS_PROD,
      CS_ACC,
      CS_POST,
      CS_MUL,
      CS_NUM,
      CS_ROUND,
      CS_DIV,
      CS_WRITE,
      CS_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic read;
      logic finish;
      logic setup;
      logic pair_init;
      logic rd_j;
      logic prod;
      logic acc;
      logic post;
      logic mul_step;
      logic num;
      logic round;
      logic div_step;
      logic write_entry;
      logic done;
   } lce_cmd_type;

   typedef struct packed {
      logic compute_ok;
      logic k_last;
      logic mul_last;
      logic div_last;
      logic pair_last;
   } lce_stat_type;

endpackage

### src/lce_ctrl.sv
// Sequencer of the lagged covariance engine: load, finish and matrix pass.
`include "assert_macros.svh"
module lce_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_command,
   input  logic                  req_last_sample,
   input  lce_pkg::lce_stat_type stat,
   output logic                  busy,
   output lce_pkg::lce_cmd_type  cmd
);
   import lce_pkg::*;

   ctrl_state_type                 state_ff;
   ctrl_state_type                 state_in;
   logic [$bits(lce_cmd_type)-1:0] cmd_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (start && req_command == CMD_LOAD && req_last_sample) begin
               state_in = CS_FINISH;
            end
         end
         CS_FINISH: state_in = stat.compute_ok ? CS_SETUP : CS_IDLE;
         CS_SETUP:  state_in = CS_PAIR;
         CS_PAIR:   state_in = CS_RD_I;
         CS_RD_I:   state_in = CS_RD_J;
         CS_RD_J:   state_in = CS_PROD;
         CS_PROD:   state_in = CS_ACC;
         CS_ACC:    state_in = stat.k_last ? CS_POST : CS_RD_I;
         CS_POST:   state_in = CS_MUL;
         CS_MUL:    state_in = stat.mul_last ? CS_NUM : CS_MUL;
         CS_NUM:    state_in = CS_ROUND;
         CS_ROUND:  state_in = CS_DIV;
         CS_DIV:    state_in = stat.div_last ? CS_WRITE : CS_DIV;
         CS_WRITE:  state_in = stat.pair_last ? CS_DONE : CS_PAIR;
         CS_DONE:   state_in = CS_IDLE;
         default:   state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         CS_IDLE: begin
            busy     = 1'b0;
            cmd.load = start && req_command == CMD_LOAD;
            cmd.read = start && req_command == CMD_READ;
         end
         CS_FINISH: cmd.finish      = 1'b1;
         CS_SETUP:  cmd.setup       = 1'b1;
         CS_PAIR:   cmd.pair_init   = 1'b1;
         CS_RD_I:   cmd             = '0;
         CS_RD_J:   cmd.rd_j        = 1'b1;
         CS_PROD:   cmd.prod        = 1'b1;
         CS_ACC:    cmd.acc         = 1'b1;
         CS_POST:   cmd.post        = 1'b1;
         CS_MUL:    cmd.mul_step    = 1'b1;
         CS_NUM:    cmd.num         = 1'b1;
         CS_ROUND:  cmd.round       = 1'b1;
         CS_DIV:    cmd.div_step    = 1'b1;
         CS_WRITE:  cmd.write_entry = 1'b1;
         CS_DONE:   cmd.done        = 1'b1;
         default:   cmd             = '0;
      endcase
   end

   assign cmd_bits = cmd;

   `ASSERT_NEXT_CYCLE(a_last_load_busy, clock, reset,
      start && !busy && req_command == CMD_LOAD && req_last_sample, busy)
   `ASSERT_SAME_CYCLE(a_cmd_onehot, clock, reset, 1'b1, $onehot0(cmd_bits))
   `ASSERT_NEXT_CYCLE(a_write_next_pair, clock, reset,
      state_ff == CS_WRITE && !stat.pair_last, state_ff == CS_PAIR)

endmodule

### src/lce_dpath.sv
// Datapath: sample store, accumulators, bit-serial multiply and divide, matrices.
module lce_dpath #(
   parameter int MAX_FEATURES = 8,
   parameter int MAX_FRAMES   = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lce_pkg::lce_cmd_type  cmd,
   input  logic [3:0]            num_features,
   input  logic [9:0]            lag_frames,
   input  logic signed [31:0]    req_sample,
   input  logic [2:0]            req_row_index,
   input  logic [2:0]            req_col_index,
   output lce_pkg::lce_stat_type stat,
   output logic                  rsp_valid,
   output logic signed [63:0]    rsp_c0_entry,
   output logic signed [63:0]    rsp_ct_entry,
   output logic [1:0]            rsp_status
);
   import lce_pkg::*;

   localparam int FI_W   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int NF_W   = $clog2(MAX_FEATURES + 1);
   localparam int FR_W   = $clog2(MAX_FRAMES + 1);
   localparam int DEPTH  = MAX_FEATURES * MAX_FRAMES;
   localparam int SA_W   = $clog2(DEPTH);
   localparam int SB_W   = $clog2(DEPTH + 1);
   localparam int MDEPTH = MAX_FEATURES * MAX_FEATURES;
   localparam int MA_W   = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
   localparam int TW_W   = $clog2(2 * MAX_FRAMES + 1);
   localparam int DEN_W  = 2 * TW_W;
   localparam int SUM_W  = 33 + $clog2(2 * MAX_FRAMES);
   localparam int ACC_W  = 65 + $clog2(2 * MAX_FRAMES);
   localparam int NUM_W  = ((ACC_W + TW_W > 2 * SUM_W) ? ACC_W + TW_W : 2 * SUM_W) + 3;
   localparam int ST_W   = $clog2(NUM_W + 1);

   // sample store and matrices
   logic signed [31:0] store_mem [DEPTH];
   logic [63:0]        c0_mem [MDEPTH];
   logic [63:0]        ct_mem [MDEPTH];

   // series control
   logic             active_ff, done_ff, ovf_ff;
   logic [1:0]       status_ff;
   logic [FR_W-1:0]  frames_ff;
   logic [FI_W-1:0]  pos_ff;
   logic [NF_W-1:0]  nf_ff;
   logic [SB_W-1:0]  fbase_ff;

   logic             new_series;
   logic [FR_W-1:0]  eff_frames;
   logic [FI_W-1:0]  eff_pos;
   logic [NF_W-1:0]  eff_nf, clamp_nf;
   logic [SB_W-1:0]  eff_base;
   logic             eff_ovf;

   // matrix pass
   logic [FR_W-1:0]     m_ff, k_ff;
   logic [TW_W-1:0]     twom_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [SB_W-1:0]     lagbase_ff, xbase_ff, ybase_ff;
   logic [FI_W-1:0]     i_ff, j_ff;
   logic [MA_W-1:0]     rowbase_ff;
   logic [SA_W-1:0]     addr_a, addr_b;
   logic signed [31:0]  rd_a_ff, rd_b_ff, xi_ff, yi_ff;
   logic signed [63:0]  pxx_ff, pyy_ff, pxy_ff, pyx_ff;
   logic signed [63:0]  pxx_in, pyy_in, pxy_in, pyx_in;
   logic signed [ACC_W-1:0] p_ff, q_ff;
   logic signed [SUM_W-1:0] si_ff, sj_ff;

   // multiply and divide lanes: lane 0 for C0, lane 1 for Ct
   logic signed [NUM_W-1:0] pm_ff [2];
   logic signed [NUM_W-1:0] nacc_ff [2];
   logic signed [NUM_W-1:0] n_ff [2];
   logic [NUM_W-1:0]        dvd_ff [2];
   logic [NUM_W-1:0]        quo_ff [2];
   logic [DEN_W-1:0]        rem_ff [2];
   logic                    neg_ff [2];
   logic [NUM_W-1:0]        dvd_in [2];
   logic [NUM_W-1:0]        quo_in [2];
   logic [DEN_W-1:0]        rem_in [2];
   logic signed [NUM_W-1:0] ssm_ff, ss_ff;
   logic [SUM_W-1:0]        sjmag_ff;
   logic                    sjneg_ff;
   logic [TW_W-1:0]         twsh_ff;
   logic [ST_W-1:0]         step_ff;

   // response
   logic             rsp_valid_ff, rsp_keep_ff;
   logic [1:0]       rsp_status_ff;
   logic [63:0]      c0_rd_ff, ct_rd_ff;
   logic [MA_W-1:0]  mat_rd_addr, mat_wr_addr;

   function automatic logic [63:0] sat64(input logic neg, input logic [NUM_W-1:0] q);
      logic [63:0] r;
      if (neg) begin
         if (q > NUM_W'(64'h8000_0000_0000_0000)) r = 64'h8000_0000_0000_0000;
         else r = 64'h0 - q[63:0];
      end else begin
         if (q > NUM_W'(64'h7FFF_FFFF_FFFF_FFFF)) r = 64'h7FFF_FFFF_FFFF_FFFF;
         else r = q[63:0];
      end
      return r;
   endfunction

   // effective series state for an accepted load
   always_comb begin
      new_series = !active_ff || done_ff;
      if (int'(num_features) == 0) clamp_nf = NF_W'(1);
      else if (int'(num_features) > MAX_FEATURES) clamp_nf = NF_W'(MAX_FEATURES);
      else clamp_nf = NF_W'(num_features);
      eff_frames = new_series ? '0 : frames_ff;
      eff_pos    = new_series ? '0 : pos_ff;
      eff_nf     = new_series ? clamp_nf : nf_ff;
      eff_base   = new_series ? '0 : fbase_ff;
      eff_ovf    = new_series ? 1'b0 : ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         ovf_ff    <= 1'b0;
         status_ff <= ST_NONE;
         frames_ff <= '0;
         pos_ff    <= '0;
         nf_ff     <= NF_W'(1);
         fbase_ff  <= '0;
      end else begin
         if (cmd.load) begin
            active_ff <= 1'b1;
            done_ff   <= 1'b0;
            nf_ff     <= eff_nf;
            if (new_series) status_ff <= ST_NONE;
            if (eff_frames >= FR_W'(MAX_FRAMES)) begin
               ovf_ff    <= 1'b1;
               frames_ff <= eff_frames;
               pos_ff    <= eff_pos;
               fbase_ff  <= eff_base;
            end else begin
               ovf_ff <= eff_ovf;
               if (int'(eff_pos) + 1 >= int'(eff_nf)) begin
                  pos_ff    <= '0;
                  frames_ff <= eff_frames + 1'b1;
                  fbase_ff  <= eff_base + SB_W'(MAX_FEATURES);
               end else begin
                  pos_ff    <= eff_pos + 1'b1;
                  frames_ff <= eff_frames;
                  fbase_ff  <= eff_base;
               end
            end
         end
         if (cmd.finish) begin
            done_ff <= 1'b1;
            if (ovf_ff) status_ff <= ST_OVF;
            else if (int'(lag_frames) >= int'(frames_ff)) status_ff <= ST_LAG;
         end
         if (cmd.done) status_ff <= ST_OK;
      end
   end

   // store write on loads that fit, two registered read ports for the pass
   always_ff @(posedge clock) begin
      if (cmd.load && eff_frames < FR_W'(MAX_FRAMES)) begin
         store_mem[SA_W'(eff_base + SB_W'(eff_pos))] <= req_sample;
      end
      rd_a_ff <= store_mem[addr_a];
      rd_b_ff <= store_mem[addr_b];
   end

   always_comb begin
      if (cmd.rd_j) begin
         addr_a = SA_W'(xbase_ff + SB_W'(j_ff));
         addr_b = SA_W'(ybase_ff + SB_W'(j_ff));
      end else begin
         addr_a = SA_W'(xbase_ff + SB_W'(i_ff));
         addr_b = SA_W'(ybase_ff + SB_W'(i_ff));
      end
   end

   assign pxx_in = xi_ff * rd_a_ff;
   assign pyy_in = yi_ff * rd_b_ff;
   assign pxy_in = xi_ff * rd_b_ff;
   assign pyx_in = yi_ff * rd_a_ff;

   assign stat.compute_ok = !ovf_ff && int'(lag_frames) < int'(frames_ff);
   assign stat.k_last     = (k_ff + 1'b1) == m_ff;
   assign stat.mul_last   = step_ff == ST_W'(SUM_W - 1);
   assign stat.div_last   = step_ff == ST_W'(NUM_W - 1);
   assign stat.pair_last  = int'(i_ff) + 1 == int'(nf_ff) && int'(j_ff) + 1 == int'(nf_ff);

   // divide step per lane: shift in one dividend bit, subtract when it fits
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         logic [DEN_W:0] trial;
         trial = {rem_ff[l], dvd_ff[l][NUM_W-1]};
         if (trial >= {1'b0, den_ff}) begin
            rem_in[l] = DEN_W'(trial - {1'b0, den_ff});
            quo_in[l] = {quo_ff[l][NUM_W-2:0], 1'b1};
         end else begin
            rem_in[l] = trial[DEN_W-1:0];
            quo_in[l] = {quo_ff[l][NUM_W-2:0], 1'b0};
         end
         dvd_in[l] = {dvd_ff[l][NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         m_ff       <= frames_ff - FR_W'(lag_frames);
         twom_ff    <= TW_W'(2 * int'(frames_ff - FR_W'(lag_frames)));
         lagbase_ff <= SB_W'(lag_frames * MAX_FEATURES);
         i_ff       <= '0;
         j_ff       <= '0;
         rowbase_ff <= '0;
      end
      if (cmd.setup) begin
         den_ff <= DEN_W'(twom_ff) * DEN_W'(twom_ff);
      end
      if (cmd.pair_init) begin
         p_ff     <= '0;
         q_ff     <= '0;
         si_ff    <= '0;
         sj_ff    <= '0;
         k_ff     <= '0;
         xbase_ff <= '0;
         ybase_ff <= lagbase_ff;
      end
      if (cmd.rd_j) begin
         xi_ff <= rd_a_ff;
         yi_ff <= rd_b_ff;
         si_ff <= si_ff + SUM_W'(rd_a_ff) + SUM_W'(rd_b_ff);
      end
      if (cmd.prod) begin
         pxx_ff <= pxx_in;
         pyy_ff <= pyy_in;
         pxy_ff <= pxy_in;
         pyx_ff <= pyx_in;
         sj_ff  <= sj_ff + SUM_W'(rd_a_ff) + SUM_W'(rd_b_ff);
      end
      if (cmd.acc) begin
         p_ff     <= p_ff + ACC_W'(pxx_ff) + ACC_W'(pyy_ff);
         q_ff     <= q_ff + ACC_W'(pxy_ff) + ACC_W'(pyx_ff);
         k_ff     <= k_ff + 1'b1;
         xbase_ff <= xbase_ff + SB_W'(MAX_FEATURES);
         ybase_ff <= ybase_ff + SB_W'(MAX_FEATURES);
      end
      if (cmd.post) begin
         pm_ff[0]   <= NUM_W'(p_ff);
         pm_ff[1]   <= NUM_W'(q_ff);
         nacc_ff[0] <= '0;
         nacc_ff[1] <= '0;
         ssm_ff     <= NUM_W'(si_ff);
         ss_ff      <= '0;
         sjneg_ff   <= sj_ff[SUM_W-1];
         sjmag_ff   <= sj_ff[SUM_W-1] ? SUM_W'(-sj_ff) : SUM_W'(sj_ff);
         twsh_ff    <= twom_ff;
         step_ff    <= '0;
      end
      if (cmd.mul_step) begin
         for (int l = 0; l < 2; l++) begin
            if (twsh_ff[0]) nacc_ff[l] <= nacc_ff[l] + pm_ff[l];
            pm_ff[l] <= pm_ff[l] <<< 1;
         end
         if (sjmag_ff[0]) ss_ff <= ss_ff + ssm_ff;
         ssm_ff   <= ssm_ff <<< 1;
         sjmag_ff <= sjmag_ff >> 1;
         twsh_ff  <= twsh_ff >> 1;
         step_ff  <= step_ff + 1'b1;
      end
      if (cmd.num) begin
         for (int l = 0; l < 2; l++) begin
            n_ff[l] <= sjneg_ff ? nacc_ff[l] + ss_ff : nacc_ff[l] - ss_ff;
         end
      end
      if (cmd.round) begin
         for (int l = 0; l < 2; l++) begin
            neg_ff[l] <= n_ff[l][NUM_W-1];
            dvd_ff[l] <= (n_ff[l][NUM_W-1] ? NUM_W'(-n_ff[l]) : NUM_W'(n_ff[l]))
                         + NUM_W'(den_ff >> 1);
            rem_ff[l] <= '0;
            quo_ff[l] <= '0;
         end
         step_ff <= '0;
      end
      if (cmd.div_step) begin
         for (int l = 0; l < 2; l++) begin
            dvd_ff[l] <= dvd_in[l];
            rem_ff[l] <= rem_in[l];
            quo_ff[l] <= quo_in[l];
         end
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.write_entry) begin
         if (int'(j_ff) + 1 >= int'(nf_ff)) begin
            j_ff       <= '0;
            i_ff       <= i_ff + 1'b1;
            rowbase_ff <= rowbase_ff + MA_W'(MAX_FEATURES);
         end else begin
            j_ff <= j_ff + 1'b1;
         end
      end
   end

   // matrix memories: write after each divide, registered read for requests
   assign mat_wr_addr = MA_W'(rowbase_ff + MA_W'(j_ff));
   assign mat_rd_addr = MA_W'(int'(req_row_index) * MAX_FEATURES + int'(req_col_index));

   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         c0_mem[mat_wr_addr] <= sat64(neg_ff[0], quo_ff[0]);
         ct_mem[mat_wr_addr] <= sat64(neg_ff[1], quo_ff[1]);
      end
      if (cmd.read) begin
         c0_rd_ff <= c0_mem[mat_rd_addr];
         ct_rd_ff <= ct_mem[mat_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.read;
      end
      if (cmd.read) begin
         rsp_status_ff <= status_ff;
         rsp_keep_ff   <= status_ff == ST_OK
                          && int'(req_row_index) < int'(nf_ff)
                          && int'(req_col_index) < int'(nf_ff);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_c0_entry = rsp_keep_ff ? $signed(c0_rd_ff) : 64'sd0;
   assign rsp_ct_entry = rsp_keep_ff ? $signed(ct_rd_ff) : 64'sd0;

endmodule

### src/lagged_covariance_engine_core.sv
// Top level of the lagged covariance engine: configuration registers and wiring.
//
// Loads one Q16.16 sample per transaction into a frame-ordered store; the
// transaction flagged last_sample closes the series and, when no overflow
// occurred and lag_frames is below the number of complete frames N, runs the
// matrix pass that fills C0 and Ct (Q32.32, rounded half away from zero,
// saturated). Loads and reads are accepted one per clock while busy is low;
// a read answers with rsp_valid for exactly one cycle, in the cycle after its
// acceptance, and the receiver cannot stall it. After the last load busy is
// high through the finish step on an error, otherwise through the matrix
// pass too; its multiply works over SUM_W = 33+clog2(2*MAX_FRAMES) bits and
// its divide over the NUM_W-bit numerator (44 and 91 at the default sizes).
// Per frame step the two read ports of the sample store fetch four samples
// in states RD_I and RD_J, then come a product and an accumulate state; the
// multiply is bit-serial and the divide restoring, one bit per cycle. No
// clearing pass after reset: matrix entries are masked to zero unless the last
// series finished OK and both indices lie below the feature count.
// Configuration: csr_index 0 is num_features, 1 is lag_frames; write only
// while idle.
module lagged_covariance_engine_core #(
   parameter int MAX_FEATURES = 8,
   parameter int MAX_FRAMES   = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic signed [31:0] req_sample,
   input  logic               req_last_sample,
   input  logic [2:0]         req_row_index,
   input  logic [2:0]         req_col_index,
   output logic               rsp_valid,
   output logic signed [63:0] rsp_c0_entry,
   output logic signed [63:0] rsp_ct_entry,
   output logic [1:0]         rsp_status,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [9:0]         csr_data
);
   import lce_pkg::*;

   logic [3:0]   num_features_ff;
   logic [9:0]   lag_frames_ff;
   lce_cmd_type  cmd;
   lce_stat_type stat;

   // Hold the configuration; reset values give one feature and a lag of one.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_features_ff <= 4'd1;
         lag_frames_ff   <= 10'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_NUM_FEATURES: num_features_ff <= csr_data[3:0];
            CSR_LAG_FRAMES:   lag_frames_ff   <= csr_data;
            default:          lag_frames_ff   <= lag_frames_ff;
         endcase
      end
   end

   // Sequence loads, the series finish and the matrix pass.
   lce_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_command     (req_command),
      .req_last_sample (req_last_sample),
      .stat            (stat),
      .busy            (busy),
      .cmd             (cmd)
   );

   // Store samples, accumulate, multiply, divide and answer reads.
   lce_dpath #(
      .MAX_FEATURES (MAX_FEATURES),
      .MAX_FRAMES   (MAX_FRAMES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .num_features    (num_features_ff),
      .lag_frames      (lag_frames_ff),
      .req_sample      (req_sample),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_c0_entry    (rsp_c0_entry),
      .rsp_ct_entry    (rsp_ct_entry),
      .rsp_status      (rsp_status)
   );

endmodule
